FILE: hw/rtl/sap_pkg.sv
package sap_pkg;

  typedef enum logic [1:0] {
    PH_SIG  = 2'd0,
    PH_HDR  = 2'd1,
    PH_BIN  = 2'd2,
    PH_STOP = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    NP_LEAD   = 3'd0,
    NP_SIGN   = 3'd1,
    NP_ZERO   = 3'd2,
    NP_PREFIX = 3'd3,
    NP_DIGITS = 3'd4,
    NP_DONE   = 3'd5
  } nphase_t;

  localparam logic [1:0] KIND_WRITE   = 2'd0;
  localparam logic [1:0] KIND_SETTING = 2'd1;
  localparam logic [1:0] KIND_FINISH  = 2'd2;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_SIG      = 3'd1;
  localparam logic [2:0] ERR_HDR_END  = 3'd2;
  localparam logic [2:0] ERR_FF_LINE  = 3'd3;
  localparam logic [2:0] ERR_SEG_END  = 3'd4;

  localparam logic [3:0] KW_TYPE   = 4'd3;
  localparam logic [3:0] KW_STEREO = 4'd7;
  localparam logic [3:0] KW_NONE   = 4'd15;
  localparam logic [2:0] TYPE_NONE = 3'd7;

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;

  typedef struct packed {
    logic        valid;
    logic [1:0]  kind;
    logic [15:0] address;
    logic [7:0]  data;
    logic [2:0]  setting;
    logic [15:0] value;
    logic        loaded;
    logic        stereo;
    logic [2:0]  error_code;
  } result_t;

  function automatic logic [3:0] kw_len(input logic [3:0] j);
    case (j)
      4'd0: kw_len = 4'd6;
      4'd1: kw_len = 4'd5;
      4'd2: kw_len = 4'd4;
      4'd3: kw_len = 4'd4;
      4'd4: kw_len = 4'd5;
      4'd5: kw_len = 4'd7;
      4'd6: kw_len = 4'd8;
      4'd7: kw_len = 4'd6;
      4'd8: kw_len = 4'd4;
      default: kw_len = 4'd0;
    endcase
  endfunction

  function automatic logic [7:0] kw_char(input logic [3:0] j, input logic [3:0] p);
    logic [63:0] s;
    s = 64'h0;
    case (j)
      4'd0: s = "PLAYER";
      4'd1: s = "MUSIC";
      4'd2: s = "INIT";
      4'd3: s = "TYPE";
      4'd4: s = "SONGS";
      4'd5: s = "DEFSONG";
      4'd6: s = "FASTPLAY";
      4'd7: s = "STEREO";
      4'd8: s = "TIME";
      default: s = 64'h0;
    endcase
    kw_char = 8'h00;
    if (p < kw_len(j)) begin
      kw_char = s[8*(kw_len(j) - 4'd1 - p) +: 8];
    end
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    is_blank = (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
  endfunction

endpackage

FILE: hw/rtl/music_file_header_segment_parser_top.sv
// Channel  | Ports                               | Direction
// input    | in_valid, in_stall, in_file_byte,   | in
//          | in_end_mark                          |
// result   | out_valid, out_stall, out_kind ...  | out
// One transaction is accepted per cycle while in_stall is low; any result it yields is registered before it leaves.
// A result passes through the single decode stage and then the output register.
// A skid stage absorbs one result when the output is stalled; in_stall then rises.
// Synchronous active-low reset returns the parser to the signature phase.
module music_file_header_segment_parser_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_file_byte,
  input  logic        in_end_mark,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [15:0] out_address,
  output logic [7:0]  out_data,
  output logic [2:0]  out_setting,
  output logic [15:0] out_value,
  output logic        out_loaded,
  output logic        out_stereo,
  output logic [2:0]  out_error_code
);
  import sap_pkg::*;

  logic    take;
  result_t res, q;

  sap_core u_core (
    .clk(clk), .rst_n(rst_n), .take(take),
    .byte_i(in_file_byte), .end_i(in_end_mark), .res(res)
  );

  sap_outreg u_out (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .res(res), .take(take), .out_valid(out_valid), .out_stall(out_stall), .out_r(q)
  );

  assign out_kind = q.kind;
  assign out_address = q.address;
  assign out_data = q.data;
  assign out_setting = q.setting;
  assign out_value = q.value;
  assign out_loaded = q.loaded;
  assign out_stereo = q.stereo;
  assign out_error_code = q.error_code;
endmodule

FILE: hw/rtl/sap_core.sv
module sap_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            take,
  input  logic [7:0]      byte_i,
  input  logic            end_i,
  output sap_pkg::result_t res
);
  import sap_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  pos_r, pos_nxt;
  logic        sigm_r, sigm_nxt;
  logic [8:0]  cand_r, cand_nxt;
  logic [3:0]  kw_r, kw_nxt;
  nphase_t     np_r, np_nxt;
  logic [16:0] num_r, num_nxt;
  logic        tdone_r, tdone_nxt;
  logic [2:0]  tl_r, tl_nxt;
  logic        st_r, st_nxt;
  logic [2:0]  hbc_r, hbc_nxt;
  logic [7:0]  fhb_r, fhb_nxt;
  logic [15:0] sa_r, sa_nxt;
  logic [15:0] se_r, se_nxt;
  logic [2:0]  err_r, err_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SIG;
      pos_r   <= '0;
      sigm_r  <= 1'b1;
      cand_r  <= '1;
      kw_r    <= KW_NONE;
      np_r    <= NP_LEAD;
      num_r   <= '0;
      tdone_r <= 1'b0;
      tl_r    <= TYPE_NONE;
      st_r    <= 1'b0;
      hbc_r   <= '0;
      fhb_r   <= '0;
      sa_r    <= '0;
      se_r    <= '0;
      err_r   <= ERR_NONE;
    end else if (take) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      sigm_r  <= sigm_nxt;
      cand_r  <= cand_nxt;
      kw_r    <= kw_nxt;
      np_r    <= np_nxt;
      num_r   <= num_nxt;
      tdone_r <= tdone_nxt;
      tl_r    <= tl_nxt;
      st_r    <= st_nxt;
      hbc_r   <= hbc_nxt;
      fhb_r   <= fhb_nxt;
      sa_r    <= sa_nxt;
      se_r    <= se_nxt;
      err_r   <= err_nxt;
    end
  end

  function automatic logic [4:0] digit_of(input logic [7:0] b, input logic hex);
    digit_of = 5'h10;
    if (b >= "0" && b <= "9") begin
      digit_of = {1'b0, 4'(b - "0")};
    end else if (hex && b >= "a" && b <= "f") begin
      digit_of = {1'b0, 4'(b - "a" + 8'd10)};
    end else if (hex && b >= "A" && b <= "F") begin
      digit_of = {1'b0, 4'(b - "A" + 8'd10)};
    end
  endfunction

  // Number and type-letter update for one value byte of the matched keyword.
  task automatic value_byte(input logic [3:0] j, input logic [7:0] b,
                            inout nphase_t np, inout logic [16:0] nv,
                            inout logic td);
    logic        hex;
    logic [4:0]  d;
    logic [20:0] prod;
    logic        go_first;
    hex = (j <= 4'd2);
    d = digit_of(b, hex);
    prod = '0;
    go_first = 1'b0;
    if (j == KW_TYPE) begin
      if (!td) begin
        if (b == "B" || b == "b") begin
          nv = 17'd1; td = 1'b1;
        end else if (b == "C" || b == "c") begin
          nv = 17'd2; td = 1'b1;
        end else if (b == "D" || b == "d") begin
          nv = 17'd3; td = 1'b1;
        end else if (b == "S" || b == "s") begin
          nv = 17'd4; td = 1'b1;
        end else if (!(b != 8'h00 && is_blank(b))) begin
          td = 1'b1;
        end
      end
    end else if (j <= 4'd6) begin
      case (np)
        NP_LEAD: begin
          if (is_blank(b)) begin
          end else if (b == "+") begin
            np = NP_SIGN;
          end else if (b == "-") begin
            np = NP_DONE;
          end else begin
            go_first = 1'b1;
          end
        end
        NP_SIGN: go_first = 1'b1;
        NP_ZERO, NP_PREFIX: begin
          if (np == NP_ZERO && (b == "x" || b == "X")) begin
            np = NP_PREFIX;
          end else if (!d[4]) begin
            nv = {13'd0, d[3:0]}; np = NP_DIGITS;
          end else begin
            np = NP_DONE;
          end
        end
        NP_DIGITS: begin
          if (!d[4]) begin
            prod = hex ? {nv, 4'd0} : (21'(nv) * 21'd10);
            prod = prod + 21'(d[3:0]);
            nv = (prod > 21'h10000) ? 17'h10000 : prod[16:0];
          end else begin
            np = NP_DONE;
          end
        end
        default: begin
        end
      endcase
      if (go_first) begin
        if (hex && b == "0") begin
          np = NP_ZERO;
        end else if (!d[4]) begin
          nv = {13'd0, d[3:0]}; np = NP_DIGITS;
        end else begin
          np = NP_DONE;
        end
      end
    end
  endtask

  always_comb begin
    logic [3:0] kw;
    logic [8:0] cand;
    logic       found;
    phase_nxt = phase_r; pos_nxt = pos_r; sigm_nxt = sigm_r; cand_nxt = cand_r;
    kw_nxt = kw_r; np_nxt = np_r; num_nxt = num_r; tdone_nxt = tdone_r;
    tl_nxt = tl_r; st_nxt = st_r; hbc_nxt = hbc_r; fhb_nxt = fhb_r;
    sa_nxt = sa_r; se_nxt = se_r; err_nxt = err_r;
    res = '0;
    kw = kw_r;
    cand = cand_r;
    found = 1'b0;
    if (end_i) begin
      if (phase_r == PH_SIG) begin
        phase_nxt = PH_STOP; err_nxt = ERR_SIG;
      end else if (phase_r == PH_HDR) begin
        phase_nxt = PH_STOP; err_nxt = ERR_HDR_END;
      end else if (phase_r == PH_BIN) begin
        phase_nxt = PH_STOP; err_nxt = (hbc_r != 3'd0) ? ERR_SEG_END : ERR_NONE;
      end
      res.valid = 1'b1;
      res.kind = KIND_FINISH;
      res.loaded = (tl_r != TYPE_NONE);
      res.stereo = st_r;
      res.error_code = err_nxt;
    end else begin
      case (phase_r)
        PH_SIG: begin
          if (pos_r >= 4'd4) begin
            phase_nxt = PH_STOP; err_nxt = ERR_SIG;
          end else if (byte_i == CH_LF || byte_i == CH_CR) begin
            if (pos_r == 4'd3 && sigm_r) begin
              phase_nxt = PH_HDR;
              pos_nxt = '0; cand_nxt = '1; kw_nxt = KW_NONE;
              np_nxt = NP_LEAD; num_nxt = '0; tdone_nxt = 1'b0;
            end else begin
              phase_nxt = PH_STOP; err_nxt = ERR_SIG;
            end
          end else begin
            if (!((pos_r == 4'd0 && byte_i == "S") || (pos_r == 4'd1 && byte_i == "A")
                  || (pos_r == 4'd2 && byte_i == "P"))) begin
              sigm_nxt = 1'b0;
            end
            pos_nxt = pos_r + 4'd1;
          end
        end
        PH_HDR: begin
          if (byte_i == 8'hFF) begin
            if (pos_r != 4'd0) begin
              phase_nxt = PH_STOP; err_nxt = ERR_FF_LINE;
            end else begin
              phase_nxt = PH_BIN; hbc_nxt = 3'd1; fhb_nxt = 8'hFF;
            end
          end else if (byte_i == CH_LF || byte_i == CH_CR) begin
            if (pos_r != 4'd0) begin
              if (kw == KW_NONE) begin
                for (int j = 0; j < 9; j++) begin
                  if (!found && cand[j] && kw_len(4'(j)) == pos_r) begin
                    found = 1'b1; kw = 4'(j);
                  end
                end
                if (found) begin
                  value_byte(kw, 8'h00, np_nxt, num_nxt, tdone_nxt);
                end
              end
              if (kw <= 4'd6 && kw != KW_TYPE) begin
                if (num_nxt >= 17'd1 && num_nxt <= 17'hFFFF) begin
                  res.valid = 1'b1; res.kind = KIND_SETTING;
                  res.setting = kw[2:0]; res.value = num_nxt[15:0];
                end
              end else if (kw == KW_TYPE) begin
                if (num_nxt != 17'd0) begin
                  tl_nxt = {1'b0, 2'(num_nxt[1:0] - 2'd1)};
                  res.valid = 1'b1; res.kind = KIND_SETTING;
                  res.setting = KW_TYPE[2:0]; res.value = {13'd0, tl_nxt};
                end
              end else if (kw == KW_STEREO) begin
                st_nxt = 1'b1;
              end
              pos_nxt = '0; cand_nxt = '1; kw_nxt = KW_NONE;
              np_nxt = NP_LEAD; num_nxt = '0; tdone_nxt = 1'b0;
            end
          end else begin
            if (pos_r < 4'd15) pos_nxt = pos_r + 4'd1;
            if (kw == KW_NONE) begin
              for (int j = 0; j < 9; j++) begin
                if (!found && cand[j]) begin
                  if (pos_r < kw_len(4'(j)) && byte_i == kw_char(4'(j), pos_r)) begin
                  end else if (pos_r == kw_len(4'(j)) && (byte_i == " " || byte_i == 8'h00)) begin
                    found = 1'b1; kw = 4'(j);
                  end else begin
                    cand[j] = 1'b0;
                  end
                end
              end
              cand_nxt = cand;
              kw_nxt = kw;
            end
            if (kw != KW_NONE) begin
              value_byte(kw, byte_i, np_nxt, num_nxt, tdone_nxt);
            end
          end
        end
        PH_BIN: begin
          case (hbc_r)
            3'd0: begin
              fhb_nxt = byte_i; hbc_nxt = 3'd1;
            end
            3'd1: begin
              if ((fhb_r & byte_i) == 8'hFF) begin
                hbc_nxt = 3'd0;
              end else begin
                sa_nxt = {byte_i, fhb_r}; hbc_nxt = 3'd2;
              end
            end
            3'd2: begin
              se_nxt = {8'd0, byte_i}; hbc_nxt = 3'd3;
            end
            3'd3: begin
              se_nxt = {byte_i, se_r[7:0]}; hbc_nxt = 3'd4;
            end
            default: begin
              res.valid = 1'b1; res.kind = KIND_WRITE;
              res.address = sa_r; res.data = byte_i;
              if (sa_r == se_r) hbc_nxt = 3'd0;
              sa_nxt = sa_r + 16'd1;
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (take && phase_r == PH_STOP) |=> (phase_r == PH_STOP))
    else $error("left stopped phase");
  assert property (@(posedge clk) disable iff (!rst_n)
    (res.valid && res.kind == KIND_WRITE) |-> (phase_r == PH_BIN && hbc_r == 3'd4))
    else $error("write outside segment data");
  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_SIG) |-> (tl_r == TYPE_NONE && !st_r))
    else $error("setting before header");
endmodule

FILE: hw/rtl/sap_outreg.sv
module sap_outreg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  sap_pkg::result_t res,
  output logic             take,
  output logic             out_valid,
  input  logic             out_stall,
  output sap_pkg::result_t out_r
);
  import sap_pkg::*;

  logic    full_r;
  logic    skid_full_r;
  result_t q_r, skid_r;

  // Main register plus skid stage so the upstream stall output (in_stall) is registered.
  assign in_stall = skid_full_r;
  assign take = in_valid && !skid_full_r;
  assign out_valid = full_r;
  assign out_r = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else begin
      if (!full_r || !out_stall) begin
        if (skid_full_r) begin
          full_r <= 1'b1;
          skid_full_r <= 1'b0;
        end else begin
          full_r <= take && res.valid;
        end
      end else if (take && res.valid) begin
        skid_full_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!full_r || !out_stall) begin
      q_r <= skid_full_r ? skid_r : res;
    end
    if (take && res.valid && full_r && out_stall) begin
      skid_r <= res;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    skid_full_r |-> full_r)
    else $error("skid holds a transaction while output is empty");
endmodule
